// ===== sv/pat_pkg.sv =====
package pat_pkg;

   // fixed field widths of the request and response channels
   localparam int LOGICAL_ADDR_BITS = 18;
   localparam int PHYS_ADDR_BITS    = 20;
   localparam int LOAD_FRAME_BITS   = 8;
   localparam int MODE_BITS         = 2;

   // default geometry
   localparam int OFFSET_BITS_DEF      = 12;
   localparam int PAGE_NUMBER_BITS_DEF = 6;
   localparam int FRAME_BITS_DEF       = 8;

   // valid, readable, writable, referenced, modified
   localparam int ENTRY_FLAG_BITS = 5;

   // request operation codes
   typedef enum logic [MODE_BITS-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_LOAD  = 2'd2
   } mode_type;

endpackage

// ===== sv/pat_page_table.sv =====
module pat_page_table #(
   parameter int PAGE_NUMBER_BITS = pat_pkg::PAGE_NUMBER_BITS_DEF,
   parameter int ENTRY_BITS       = pat_pkg::ENTRY_FLAG_BITS + pat_pkg::FRAME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [PAGE_NUMBER_BITS-1:0] rd_page,
   output logic [ENTRY_BITS-1:0]       rd_entry,
   input  logic                        wr_en,
   input  logic [PAGE_NUMBER_BITS-1:0] wr_page,
   input  logic [ENTRY_BITS-1:0]       wr_entry,
   output logic                        ready
);

   localparam int DEPTH = 2 ** PAGE_NUMBER_BITS;

   logic [ENTRY_BITS-1:0]       entry_mem [DEPTH];
   logic [ENTRY_BITS-1:0]       rd_entry_ff;
   logic                        clear_ff;
   logic                        clear_in;
   logic [PAGE_NUMBER_BITS-1:0] clear_page_ff;
   logic [PAGE_NUMBER_BITS-1:0] clear_page_in;
   logic                        mem_we;
   logic [PAGE_NUMBER_BITS-1:0] mem_addr;
   logic [ENTRY_BITS-1:0]       mem_data;

   // clearing sweep after reset, one entry per cycle
   always_comb begin
      clear_in      = clear_ff && (clear_page_ff != {PAGE_NUMBER_BITS{1'b1}});
      clear_page_in = clear_ff ? PAGE_NUMBER_BITS'(clear_page_ff + 1'b1) : clear_page_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_page_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_page_ff <= clear_page_in;
      end
   end

   // write port shared by the sweep and the update path
   always_comb begin
      mem_we   = clear_ff || wr_en;
      mem_addr = clear_ff ? clear_page_ff : wr_page;
      mem_data = clear_ff ? '0 : wr_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_addr] <= mem_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_page];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign ready    = ~clear_ff;

endmodule

// ===== sv/paged_address_translator.sv =====
// channel   | direction | handshake            | payload
// req_      | in        | req_valid/req_stall  | mode, logical address, entry to load
// rsp_      | out       | rsp_valid/rsp_stall  | physical address, status flags, fault info
//
// one request at a time: page table read on accept, update and response register
// load when the item completes (separate read and write ports, one item in flight)
// after reset the page table is swept clear entry by entry;
// req_stall stays high during the sweep
// a stalled response holds the item in flight until the response slot frees
module paged_address_translator #(
   parameter int OFFSET_BITS      = pat_pkg::OFFSET_BITS_DEF,
   parameter int PAGE_NUMBER_BITS = pat_pkg::PAGE_NUMBER_BITS_DEF,
   parameter int FRAME_BITS       = pat_pkg::FRAME_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pat_pkg::MODE_BITS-1:0]         req_mode,
   input  logic [pat_pkg::LOGICAL_ADDR_BITS-1:0] req_logical_address,
   input  logic                                  req_load_valid,
   input  logic                                  req_load_readable,
   input  logic                                  req_load_writable,
   input  logic [pat_pkg::LOAD_FRAME_BITS-1:0]   req_load_frame,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pat_pkg::PHYS_ADDR_BITS-1:0]    rsp_physical_address,
   output logic                                  rsp_translated,
   output logic                                  rsp_page_fault,
   output logic                                  rsp_protection_error,
   output logic [pat_pkg::LOGICAL_ADDR_BITS-1:0] rsp_missed_address,
   output logic                                  rsp_fault_pending
);

   localparam int LA_BITS    = pat_pkg::LOGICAL_ADDR_BITS;
   localparam int PA_BITS    = pat_pkg::PHYS_ADDR_BITS;
   localparam int LF_BITS    = pat_pkg::LOAD_FRAME_BITS;
   localparam int ENTRY_BITS = pat_pkg::ENTRY_FLAG_BITS + FRAME_BITS;
   localparam int E_VALID    = ENTRY_BITS - 1;
   localparam int E_READ     = ENTRY_BITS - 2;
   localparam int E_WRITE    = ENTRY_BITS - 3;
   localparam int E_REF      = ENTRY_BITS - 4;
   localparam int E_MOD      = ENTRY_BITS - 5;

   // request capture and control
   logic                                  accept;
   logic                                  done;
   logic                                  busy_ff;
   logic                                  busy_in;
   logic                                  pt_ready;
   logic [pat_pkg::MODE_BITS-1:0]         mode_ff;
   logic [LA_BITS-1:0]                    laddr_ff;
   logic                                  load_valid_ff;
   logic                                  load_readable_ff;
   logic                                  load_writable_ff;
   logic [LF_BITS-1:0]                    load_frame_ff;
   logic [PAGE_NUMBER_BITS-1:0]           req_page;
   logic [PAGE_NUMBER_BITS-1:0]           page_ff;
   logic [LA_BITS+PAGE_NUMBER_BITS-1:0]   req_laddr_wide;

   // lookup result and decision
   logic [ENTRY_BITS-1:0]                 entry;
   logic [FRAME_BITS-1:0]                 entry_frame;
   logic [FRAME_BITS-1:0]                 load_frame;
   logic                                  is_load;
   logic                                  is_access;
   logic                                  is_write;
   logic                                  page_fault;
   logic                                  prot_error;
   logic                                  translated;
   logic [PA_BITS-1:0]                    phys_addr;
   logic                                  wr_en;
   logic [ENTRY_BITS-1:0]                 wr_entry;

   // response and fault registers
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic [PA_BITS-1:0]                    phys_addr_ff;
   logic                                  translated_ff;
   logic                                  page_fault_ff;
   logic                                  prot_error_ff;
   logic [LA_BITS-1:0]                    missed_addr_ff;
   logic [LA_BITS-1:0]                    missed_addr_in;
   logic                                  fault_pending_ff;
   logic                                  fault_pending_in;

   // page number of the incoming request, zero above the address width
   assign req_laddr_wide = {{PAGE_NUMBER_BITS{1'b0}}, req_logical_address};
   assign req_page       = PAGE_NUMBER_BITS'(req_laddr_wide >> OFFSET_BITS);

   // handshake control
   assign req_stall = busy_ff | ~pt_ready;
   assign accept    = req_valid & ~req_stall;
   assign done      = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      busy_in      = accept | (busy_ff & ~done);
      rsp_valid_in = done | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff          <= req_mode;
         laddr_ff         <= req_logical_address;
         page_ff          <= req_page;
         load_valid_ff    <= req_load_valid;
         load_readable_ff <= req_load_readable;
         load_writable_ff <= req_load_writable;
         load_frame_ff    <= req_load_frame;
      end
   end

   pat_page_table #(
      .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS),
      .ENTRY_BITS       (ENTRY_BITS)
   ) u_page_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_page  (req_page),
      .rd_entry (entry),
      .wr_en    (wr_en),
      .wr_page  (page_ff),
      .wr_entry (wr_entry),
      .ready    (pt_ready)
   );

   // permission check and address formation
   always_comb begin
      is_load     = (mode_ff == pat_pkg::MODE_LOAD);
      is_write    = (mode_ff == pat_pkg::MODE_WRITE);
      is_access   = (mode_ff == pat_pkg::MODE_READ) || is_write;
      entry_frame = entry[FRAME_BITS-1:0];
      load_frame  = FRAME_BITS'({{FRAME_BITS{1'b0}}, load_frame_ff});
      page_fault  = is_access & ~entry[E_VALID];
      prot_error  = is_access & entry[E_VALID] &
                    (is_write ? ~entry[E_WRITE] : ~entry[E_READ]);
      translated  = is_access & entry[E_VALID] & ~prot_error;
      phys_addr   = translated ? PA_BITS'({entry_frame, laddr_ff[OFFSET_BITS-1:0]}) : '0;
   end

   // write back: new entry on load, referenced on success, modified on a successful write
   always_comb begin
      wr_en    = done & (is_load | translated);
      wr_entry = entry;
      if (is_load) begin
         wr_entry = {load_valid_ff, load_readable_ff, load_writable_ff, 2'b00, load_frame};
      end else begin
         wr_entry[E_REF] = 1'b1;
         wr_entry[E_MOD] = entry[E_MOD] | is_write;
      end
   end

   // fault bookkeeping
   always_comb begin
      missed_addr_in   = missed_addr_ff;
      fault_pending_in = fault_pending_ff;
      if (done) begin
         if (page_fault) begin
            missed_addr_in   = laddr_ff;
            fault_pending_in = 1'b1;
         end else if (is_load) begin
            fault_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         missed_addr_ff   <= '0;
         fault_pending_ff <= 1'b0;
      end else begin
         missed_addr_ff   <= missed_addr_in;
         fault_pending_ff <= fault_pending_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (done) begin
         phys_addr_ff  <= phys_addr;
         translated_ff <= translated;
         page_fault_ff <= page_fault;
         prot_error_ff <= prot_error;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = phys_addr_ff;
   assign rsp_translated       = translated_ff;
   assign rsp_page_fault       = page_fault_ff;
   assign rsp_protection_error = prot_error_ff;
   assign rsp_missed_address   = missed_addr_ff;
   assign rsp_fault_pending    = fault_pending_ff;

   // at most one outcome flag per response
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_translated, rsp_page_fault, rsp_protection_error}))
      else $error("more than one outcome flag set");

   // untranslated responses carry a zero address
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_translated |-> rsp_physical_address == '0)
      else $error("nonzero address on untranslated response");

   // a page fault leaves a pending fault
   a_fault_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_fault |-> rsp_fault_pending)
      else $error("page fault without pending fault");

   // table writes only from an item in flight, never during the sweep
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy_ff && pt_ready)
      else $error("page table write without item in flight");

endmodule
